/* hdl/pwead_pkg.sv */
`default_nettype none

package pwead_pkg;

	localparam int SEG_COUNT       = 20;
	localparam int TOP_ALTITUDE_KM = 300;
	localparam int ALTU_W          = 19;
	localparam int SEG_W           = 5;
	localparam int DIST_W          = 17;
	localparam int HM_W            = 14;
	localparam int QUO_W           = 4;
	localparam int Y_W             = 62;
	localparam int Q62_W           = 64;
	localparam int TERMS           = 20;	// terms past 20 are zero for y below one
	localparam int QMAX            = 11;	// largest whole scale-height count below the top

	localparam logic [ALTU_W-1:0] TOP_ALT_M = ALTU_W'(TOP_ALTITUDE_KM * 1000);
	localparam logic [Q62_W-1:0]  ONE_Q62   = 64'h4000_0000_0000_0000;

	typedef logic [SEG_W-1:0] seg_idx_t;

	localparam logic [ALTU_W-1:0] SEG_BASE_M [SEG_COUNT] = '{
		19'd0, 19'd1000, 19'd2000, 19'd3000, 19'd4000, 19'd5000, 19'd6000, 19'd8000,
		19'd10000, 19'd15000, 19'd20000, 19'd30000, 19'd40000, 19'd50000, 19'd60000,
		19'd80000, 19'd100000, 19'd150000, 19'd200000, 19'd300000
	};

	localparam logic [HM_W-1:0] SEG_HM [SEG_COUNT] = '{
		14'd10420, 14'd10300, 14'd10190, 14'd10060, 14'd9950, 14'd9820, 14'd9700,
		14'd9460, 14'd9210, 14'd8160, 14'd7620, 14'd7150, 14'd6990, 14'd7060,
		14'd7240, 14'd7200, 14'd6850, 14'd7430, 14'd8970, 14'd12060
	};

	// base densities in Q62, truncated
	localparam logic [Q62_W-1:0] SEG_RHO [SEG_COUNT] = '{
		64'((128'd1225 << 62) / 128'd1000),
		64'((128'd1122 << 62) / 128'd1000),
		64'((128'd1007 << 62) / 128'd1000),
		64'((128'd909 << 62) / 128'd1000),
		64'((128'd819 << 62) / 128'd1000),
		64'((128'd763 << 62) / 128'd1000),
		64'((128'd660 << 62) / 128'd1000),
		64'((128'd526 << 62) / 128'd1000),
		64'((128'd414 << 62) / 128'd1000),
		64'((128'd195 << 62) / 128'd1000),
		64'((128'd889 << 62) / 128'd10000),
		64'((128'd184 << 62) / 128'd10000),
		64'((128'd40 << 62) / 128'd10000),
		64'((128'd103 << 62) / 128'd100000),
		64'((128'd310 << 62) / 128'd1000000),
		64'((128'd185 << 62) / 128'd10000000),
		64'((128'd560 << 62) / 128'd1000000000),
		64'((128'd208 << 62) / 128'd100000000000),
		64'((128'd254 << 62) / 128'd1000000000000),
		64'((128'd192 << 62) / 128'd10000000000000)
	};

	// exp(-1) in Q62: the series at y = 1 reduces to nested truncating divides
	localparam logic [63:0] E1_T1  = ONE_Q62 / 64'd1;
	localparam logic [63:0] E1_T2  = E1_T1 / 64'd2;
	localparam logic [63:0] E1_T3  = E1_T2 / 64'd3;
	localparam logic [63:0] E1_T4  = E1_T3 / 64'd4;
	localparam logic [63:0] E1_T5  = E1_T4 / 64'd5;
	localparam logic [63:0] E1_T6  = E1_T5 / 64'd6;
	localparam logic [63:0] E1_T7  = E1_T6 / 64'd7;
	localparam logic [63:0] E1_T8  = E1_T7 / 64'd8;
	localparam logic [63:0] E1_T9  = E1_T8 / 64'd9;
	localparam logic [63:0] E1_T10 = E1_T9 / 64'd10;
	localparam logic [63:0] E1_T11 = E1_T10 / 64'd11;
	localparam logic [63:0] E1_T12 = E1_T11 / 64'd12;
	localparam logic [63:0] E1_T13 = E1_T12 / 64'd13;
	localparam logic [63:0] E1_T14 = E1_T13 / 64'd14;
	localparam logic [63:0] E1_T15 = E1_T14 / 64'd15;
	localparam logic [63:0] E1_T16 = E1_T15 / 64'd16;
	localparam logic [63:0] E1_T17 = E1_T16 / 64'd17;
	localparam logic [63:0] E1_T18 = E1_T17 / 64'd18;
	localparam logic [63:0] E1_T19 = E1_T18 / 64'd19;
	localparam logic [63:0] E1_T20 = E1_T19 / 64'd20;
	localparam logic [63:0] E1_POS = ONE_Q62 + E1_T2 + E1_T4 + E1_T6 + E1_T8 + E1_T10
		+ E1_T12 + E1_T14 + E1_T16 + E1_T18 + E1_T20;
	localparam logic [63:0] E1_NEG = E1_T1 + E1_T3 + E1_T5 + E1_T7 + E1_T9 + E1_T11
		+ E1_T13 + E1_T15 + E1_T17 + E1_T19;
	localparam logic [63:0] E1_Q62 = E1_POS - E1_NEG;

	typedef struct packed {
		logic                zero;
		seg_idx_t            seg;
		logic [QUO_W-1:0]    quo;
	} tag_t;

	typedef struct packed {
		tag_t                tag;
		logic [Y_W-1:0]      y;
		logic [Q62_W-1:0]    pos;
		logic [Q62_W-1:0]    neg;
	} series_t;

	typedef struct packed {
		tag_t                tag;
		logic [Q62_W-1:0]    e;
	} scale_t;

endpackage

`default_nettype wire

/* hdl/pwead_mul.sv */
`default_nettype none

// 64x64 full product in two stages: four 32x32 partials, then their sum
module pwead_mul #(
	parameter int SW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [63:0]   a,
	input  wire logic [63:0]   b,
	input  wire logic [SW-1:0] side_in,
	output logic               out_valid,
	output logic [127:0]       prod,
	output logic [SW-1:0]      side_out
);

	logic          v_s1;
	logic [63:0]   p00_s1, p01_s1, p10_s1, p11_s1;
	logic [SW-1:0] side_s1;
	logic          v_s2;
	logic [127:0]  prod_s2;
	logic [SW-1:0] side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p00_s1  <= a[31:0] * b[31:0];
			p01_s1  <= a[31:0] * b[63:32];
			p10_s1  <= a[63:32] * b[31:0];
			p11_s1  <= a[63:32] * b[63:32];
			side_s1 <= side_in;
			prod_s2 <= {64'd0, p00_s1} + ({64'd0, p01_s1} << 32) + ({64'd0, p10_s1} << 32)
				+ {p11_s1, 64'd0};
			side_s2 <= side_s1;
		end
	end

	assign out_valid = v_s2;
	assign prod      = prod_s2;
	assign side_out  = side_s2;

endmodule

`default_nettype wire

/* hdl/pwead_front.sv */
`default_nettype none

// segment select, distance into segment, whole scale heights and remainder
module pwead_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire logic signed [19:0] altitude_m,
	output logic                    out_valid,
	output pwead_pkg::tag_t         out_tag,
	output logic [pwead_pkg::HM_W-1:0] out_rem
);

	logic [pwead_pkg::ALTU_W-1:0] alt;
	pwead_pkg::seg_idx_t          seg;
	logic                         above;

	logic                          v_s1, v_s2, v_s3, v_s4;
	logic [pwead_pkg::ALTU_W-1:0]  alt_s1;
	pwead_pkg::seg_idx_t           seg_s1, seg_s2, seg_s3, seg_s4;
	logic                          zero_s1, zero_s2, zero_s3, zero_s4;
	logic [pwead_pkg::DIST_W-1:0]  d_s2;
	logic [pwead_pkg::DIST_W-1:0]  r_s3;
	logic [pwead_pkg::QUO_W-1:0]   q_s3, q_s4;
	logic [pwead_pkg::HM_W-1:0]    rem_s4;

	logic [17:0]                   r3, hm3;
	logic [pwead_pkg::QUO_W-1:0]   q3;
	logic [17:0]                   r4, hm4;
	logic [pwead_pkg::QUO_W-1:0]   q4;

	always_comb begin
		above = !altitude_m[19] && (altitude_m[18:0] > pwead_pkg::TOP_ALT_M);
		alt   = (altitude_m[19] || above) ? '0 : altitude_m[18:0];
		seg   = '0;
		for (int i = 1; i < pwead_pkg::SEG_COUNT; i++) begin
			if (alt >= pwead_pkg::SEG_BASE_M[i]) begin
				seg = pwead_pkg::SEG_W'(i);
			end
		end
	end

	// upper two quotient bits
	always_comb begin
		hm3 = 18'(pwead_pkg::SEG_HM[seg_s2]);
		r3  = 18'(d_s2);
		q3  = '0;
		if (r3 >= (hm3 << 3)) begin
			r3    = r3 - (hm3 << 3);
			q3[3] = 1'b1;
		end
		if (r3 >= (hm3 << 2)) begin
			r3    = r3 - (hm3 << 2);
			q3[2] = 1'b1;
		end
	end

	// lower two quotient bits
	always_comb begin
		hm4 = 18'(pwead_pkg::SEG_HM[seg_s3]);
		r4  = 18'(r_s3);
		q4  = q_s3;
		if (r4 >= (hm4 << 1)) begin
			r4    = r4 - (hm4 << 1);
			q4[1] = 1'b1;
		end
		if (r4 >= hm4) begin
			r4    = r4 - hm4;
			q4[0] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			alt_s1  <= alt;
			seg_s1  <= seg;
			zero_s1 <= above;
			d_s2    <= pwead_pkg::DIST_W'(alt_s1 - pwead_pkg::SEG_BASE_M[seg_s1]);
			seg_s2  <= seg_s1;
			zero_s2 <= zero_s1;
			r_s3    <= r3[pwead_pkg::DIST_W-1:0];
			q_s3    <= q3;
			seg_s3  <= seg_s2;
			zero_s3 <= zero_s2;
			rem_s4  <= r4[pwead_pkg::HM_W-1:0];
			q_s4    <= q4;
			seg_s4  <= seg_s3;
			zero_s4 <= zero_s3;
		end
	end

	assign out_valid    = v_s4;
	assign out_tag.zero = zero_s4;
	assign out_tag.seg  = seg_s4;
	assign out_tag.quo  = q_s4;
	assign out_rem      = rem_s4;

endmodule

`default_nettype wire

/* hdl/pwead_fdiv.sv */
`default_nettype none

// y = floor(rem * 2^62 / hm), eight quotient bits per stage, six in the last
module pwead_fdiv (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    en,
	input  wire logic                    in_valid,
	input  wire pwead_pkg::tag_t         in_tag,
	input  wire logic [pwead_pkg::HM_W-1:0] in_rem,
	output logic                         out_valid,
	output pwead_pkg::tag_t              out_tag,
	output logic [pwead_pkg::Y_W-1:0]    out_y
);

	localparam int BITS_PER = 8;
	localparam int NSTG     = (pwead_pkg::Y_W + BITS_PER - 1) / BITS_PER;

	logic                         v_s   [NSTG+1];
	pwead_pkg::tag_t              tag_s [NSTG+1];
	logic [pwead_pkg::HM_W-1:0]   rem_s [NSTG+1];
	logic [pwead_pkg::Y_W-1:0]    y_s   [NSTG+1];

	assign v_s[0]   = in_valid;
	assign tag_s[0] = in_tag;
	assign rem_s[0] = in_rem;
	assign y_s[0]   = '0;

	for (genvar s = 0; s < NSTG; s++) begin : g_stage
		localparam int NB = ((s + 1) * BITS_PER <= pwead_pkg::Y_W) ? BITS_PER
			: pwead_pkg::Y_W - s * BITS_PER;

		logic [pwead_pkg::HM_W-1:0] r_nx;
		logic [pwead_pkg::Y_W-1:0]  y_nx;

		always_comb begin
			logic [pwead_pkg::HM_W:0] r2;
			logic [pwead_pkg::HM_W:0] hm;
			hm   = {1'b0, pwead_pkg::SEG_HM[tag_s[s].seg]};
			r_nx = rem_s[s];
			y_nx = y_s[s];
			for (int b = 0; b < NB; b++) begin
				r2 = {r_nx, 1'b0};
				if (r2 >= hm) begin
					r2   = r2 - hm;
					y_nx = {y_nx[pwead_pkg::Y_W-2:0], 1'b1};
				end else begin
					y_nx = {y_nx[pwead_pkg::Y_W-2:0], 1'b0};
				end
				r_nx = r2[pwead_pkg::HM_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[s+1] <= 1'b0;
			end else if (en) begin
				v_s[s+1] <= v_s[s];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[s+1] <= tag_s[s];
				rem_s[s+1] <= r_nx;
				y_s[s+1]   <= y_nx;
			end
		end
	end

	assign out_valid = v_s[NSTG];
	assign out_tag   = tag_s[NSTG];
	assign out_y     = y_s[NSTG];

endmodule

`default_nettype wire

/* hdl/pwead_term.sv */
`default_nettype none

// one series term: t_k = floor(floor(t * y / 2^62) / K), and folds t_(K-1) into the sums
module pwead_term #(
	parameter int K = 3
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic [63:0]          t_in,
	input  wire pwead_pkg::series_t   side_in,
	output logic                      out_valid,
	output logic [63:0]               t_out,
	output pwead_pkg::series_t        side_out
);

	localparam bit IS_POW2 = ((K & (K - 1)) == 0);
	localparam int SHIFT   = $clog2(K);
	localparam bit PREV_ODD = (((K - 1) % 2) == 1);
	localparam int SWS     = $bits(pwead_pkg::series_t);

	pwead_pkg::series_t side_acc;
	logic               v1;
	logic [127:0]       prod1;
	pwead_pkg::series_t side1;
	logic [63:0]        p;

	always_comb begin
		side_acc = side_in;
		if (PREV_ODD) begin
			side_acc.neg = side_in.neg + t_in;
		end else begin
			side_acc.pos = side_in.pos + t_in;
		end
	end

	pwead_mul #(.SW(SWS)) u_mul_ty (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.a        (t_in),
		.b        ({2'b00, side_in.y}),
		.side_in  (side_acc),
		.out_valid(v1),
		.prod     (prod1),
		.side_out (side1)
	);

	assign p = prod1[125:62];

	if (IS_POW2) begin : g_shift
		assign out_valid = v1;
		assign t_out     = p >> SHIFT;
		assign side_out  = side1;
	end else begin : g_recip
		localparam logic [63:0] RECIP = 64'((65'd1 << 64) / K);

		logic               v2;
		logic [127:0]       prod2;
		logic [SWS+63:0]    side2;
		logic [63:0]        p2, q0, rem;
		logic               v_s3;
		logic [63:0]        t_s3;
		pwead_pkg::series_t side_s3;

		pwead_mul #(.SW(SWS + 64)) u_mul_recip (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (v1),
			.a        (p),
			.b        (RECIP),
			.side_in  ({p, side1}),
			.out_valid(v2),
			.prod     (prod2),
			.side_out (side2)
		);

		// estimate is low by at most one
		assign p2  = side2[SWS+63:SWS];
		assign q0  = prod2[127:64];
		assign rem = p2 - 64'(q0 * 64'(K));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s3 <= 1'b0;
			end else if (en) begin
				v_s3 <= v2;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				t_s3    <= (rem >= 64'(K)) ? q0 + 64'd1 : q0;
				side_s3 <= pwead_pkg::series_t'(side2[SWS-1:0]);
			end
		end

		assign out_valid = v_s3;
		assign t_out     = t_s3;
		assign side_out  = side_s3;
	end

endmodule

`default_nettype wire

/* hdl/pwead_series.sv */
`default_nettype none

// exp(-y) in Q62 as an alternating series, one term section after another
module pwead_series (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  in_valid,
	input  wire pwead_pkg::tag_t       in_tag,
	input  wire logic [pwead_pkg::Y_W-1:0] in_y,
	output logic                       out_valid,
	output pwead_pkg::tag_t            out_tag,
	output logic [63:0]                out_e
);

	localparam int N = pwead_pkg::TERMS;

	logic               v_c [N+1];
	logic [63:0]        t_c [N+1];
	pwead_pkg::series_t s_c [N+1];

	logic               v_f1, v_f2;
	pwead_pkg::tag_t    tag_f1, tag_f2;
	logic [63:0]        pos_f1, neg_f1, e_f2;

	assign v_c[0]     = in_valid;
	assign t_c[0]     = pwead_pkg::ONE_Q62;
	assign s_c[0].tag = in_tag;
	assign s_c[0].y   = in_y;
	assign s_c[0].pos = '0;
	assign s_c[0].neg = '0;

	for (genvar k = 1; k <= N; k++) begin : g_term
		pwead_term #(.K(k)) u_term (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (v_c[k-1]),
			.t_in     (t_c[k-1]),
			.side_in  (s_c[k-1]),
			.out_valid(v_c[k]),
			.t_out    (t_c[k]),
			.side_out (s_c[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f1 <= 1'b0;
			v_f2 <= 1'b0;
		end else if (en) begin
			v_f1 <= v_c[N];
			v_f2 <= v_f1;
		end
	end

	// last term has even index; clamp a negative difference to zero
	always_ff @(posedge clk) begin
		if (en) begin
			pos_f1 <= (N % 2 == 0) ? s_c[N].pos + t_c[N] : s_c[N].pos;
			neg_f1 <= (N % 2 == 0) ? s_c[N].neg : s_c[N].neg + t_c[N];
			tag_f1 <= s_c[N].tag;
			e_f2   <= (pos_f1 > neg_f1) ? pos_f1 - neg_f1 : '0;
			tag_f2 <= tag_f1;
		end
	end

	assign out_valid = v_f2;
	assign out_tag   = tag_f2;
	assign out_e     = e_f2;

endmodule

`default_nettype wire

/* hdl/pwead_scale.sv */
`default_nettype none

// apply exp(-1) once per whole scale height, then the base density, then round
module pwead_scale #(
	parameter int FRACTION_BITS = 56
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire pwead_pkg::tag_t  in_tag,
	input  wire logic [63:0]      in_e,
	output logic                  out_valid,
	output logic [FRACTION_BITS:0] density
);

	localparam int NQ  = pwead_pkg::QMAX;
	localparam int SWC = $bits(pwead_pkg::scale_t);
	localparam int SH  = 124 - FRACTION_BITS;
	localparam logic [127:0] RND = 128'd1 << (SH - 1);

	logic              v_c [NQ+1];
	pwead_pkg::scale_t s_c [NQ+1];

	assign v_c[0]     = in_valid;
	assign s_c[0].tag = in_tag;
	assign s_c[0].e   = in_e;

	for (genvar j = 0; j < NQ; j++) begin : g_pow
		logic              v_m;
		logic [127:0]      prod_m;
		pwead_pkg::scale_t side_m;

		pwead_mul #(.SW(SWC)) u_mul_e1 (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (v_c[j]),
			.a        (s_c[j].e),
			.b        (pwead_pkg::E1_Q62),
			.side_in  (s_c[j]),
			.out_valid(v_m),
			.prod     (prod_m),
			.side_out (side_m)
		);

		// keep the product only while more scale heights remain
		always_comb begin
			s_c[j+1] = side_m;
			if (side_m.tag.quo > pwead_pkg::QUO_W'(j)) begin
				s_c[j+1].e = prod_m[125:62];
			end
		end
		assign v_c[j+1] = v_m;
	end

	logic                  v_r;
	logic [127:0]          prod_r;
	pwead_pkg::tag_t       tag_r;
	logic                  v_o;
	logic [FRACTION_BITS:0] dens_o;
	logic [127:0]          rounded;

	pwead_mul #(.SW($bits(pwead_pkg::tag_t))) u_mul_rho (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_c[NQ]),
		.a        (pwead_pkg::SEG_RHO[s_c[NQ].tag.seg]),
		.b        (s_c[NQ].e),
		.side_in  (s_c[NQ].tag),
		.out_valid(v_r),
		.prod     (prod_r),
		.side_out (tag_r)
	);

	assign rounded = (prod_r + RND) >> SH;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o <= 1'b0;
		end else if (en) begin
			v_o <= v_r;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dens_o <= tag_r.zero ? '0 : rounded[FRACTION_BITS:0];
		end
	end

	assign out_valid = v_o;
	assign density   = dens_o;

endmodule

`default_nettype wire

/* hdl/piecewise_exponential_air_density_unit.sv */
// Air density from altitude, piecewise exponential over 20 fixed segments.
//
// Request channel: req_valid / req_ready carry altitude_m, signed meters.
// Response channel: rsp_valid / rsp_ready carry density, unsigned with
// FRACTION_BITS fraction bits, in kg per cubic meter. Altitudes below zero
// give the sea-level density; altitudes above 300 km give zero.
//
// A request passes through segment select and scale-height division,
// fraction division, the exp series (20 terms, a 64x64 multiply per term
// plus a reciprocal multiply for terms whose index is not a power of two),
// exp(-1) powers and base density scaling, and the output register.
// Throughput is one request per cycle except while the pipeline holds.
//
// The pipeline moves as one; it holds only when its last stage and the
// output register are both full and rsp_ready is low, so requests keep
// flowing while a response waits. Reset clears every valid bit; no request
// is in flight afterwards.
`default_nettype none

module piecewise_exponential_air_density_unit #(
	parameter int FRACTION_BITS = 56
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	input  wire logic signed [19:0]  altitude_m,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	output logic [FRACTION_BITS:0]   density
);

	logic                          adv, take;
	logic                          v_fr, v_fd, v_se, v_sc;
	pwead_pkg::tag_t               tag_fr, tag_fd, tag_se;
	logic [pwead_pkg::HM_W-1:0]    rem_fr;
	logic [pwead_pkg::Y_W-1:0]     y_fd;
	logic [63:0]                   e_se;
	logic [FRACTION_BITS:0]        dens_sc;
	logic                          rsp_valid_q;
	logic [FRACTION_BITS:0]        density_q;

	assign take      = !rsp_valid_q || rsp_ready;
	assign adv       = take || !v_sc;
	assign req_ready = adv;

	pwead_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (req_valid),
		.altitude_m(altitude_m),
		.out_valid (v_fr),
		.out_tag   (tag_fr),
		.out_rem   (rem_fr)
	);

	pwead_fdiv u_fdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_fr),
		.in_tag   (tag_fr),
		.in_rem   (rem_fr),
		.out_valid(v_fd),
		.out_tag  (tag_fd),
		.out_y    (y_fd)
	);

	pwead_series u_series (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_fd),
		.in_tag   (tag_fd),
		.in_y     (y_fd),
		.out_valid(v_se),
		.out_tag  (tag_se),
		.out_e    (e_se)
	);

	pwead_scale #(.FRACTION_BITS(FRACTION_BITS)) u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_se),
		.in_tag   (tag_se),
		.in_e     (e_se),
		.out_valid(v_sc),
		.density  (dens_sc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= v_sc;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			density_q <= dens_sc;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign density   = density_q;

endmodule

`default_nettype wire

/* hdl/pwead_checker.sv */
`default_nettype none

module pwead_checker #(
	parameter int FRACTION_BITS = 56
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                req_ready,
	input wire logic                rsp_valid,
	input wire logic                rsp_ready,
	input wire logic [FRACTION_BITS:0] density
);

	// a stalled response stays
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(density))
		else $error("response changed while stalled");

	// with the output register free the pipeline always takes a request
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("request refused with empty output");

	a_ready_drain: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_ready |-> req_ready)
		else $error("request refused while response drains");

endmodule

bind piecewise_exponential_air_density_unit pwead_checker #(
	.FRACTION_BITS(FRACTION_BITS)
) u_pwead_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req_ready),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.density   (density)
);

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
`default_nettype none

module tb;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_ready;
	logic signed [19:0] altitude_m = '0;
	logic               rsp_valid;
	logic               rsp_ready = 1'b0;
	logic [56:0]        density;

	piecewise_exponential_air_density_unit dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .altitude_m(altitude_m),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .density(density)
	);

	always #4 clk = ~clk;

	localparam int NSEG = 20;
	localparam int HOLD_LEN = 400;
	localparam int FLUSH_CYCLES = 200;

	// base km, density mantissa, power of ten, scale height in tens of meters
	int unsigned base_km_tab [NSEG] = '{0, 1, 2, 3, 4, 5, 6, 8, 10, 15, 20, 30, 40, 50, 60,
		80, 100, 150, 200, 300};
	int unsigned mant_tab [NSEG] = '{1225, 1122, 1007, 909, 819, 763, 660, 526, 414, 195,
		889, 184, 40, 103, 310, 185, 560, 208, 254, 192};
	int unsigned pow10_tab [NSEG] = '{3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 4, 4, 4, 5, 6, 7, 9,
		11, 12, 13};
	int unsigned htens_tab [NSEG] = '{1042, 1030, 1019, 1006, 995, 982, 970, 946, 921, 816,
		762, 715, 699, 706, 724, 720, 685, 743, 897, 1206};

	logic signed [19:0] pending_alt [$];
	logic [56:0]        density_due [$];
	int                 send_idle = 0;
	int                 recv_idle = 0;
	bit                 send_pause = 1'b0;
	bit                 req_took = 1'b0;
	int                 hold_trig = 0;
	int                 hold_seen = 0;
	int                 hold_left = 0;
	int                 mismatches = 0;
	int                 sent = 0;
	int                 received = 0;

	function automatic logic [63:0] exp_neg(logic [63:0] y);
		logic [127:0] t;
		logic [63:0]  pos, neg;
		pos = 64'h4000_0000_0000_0000;
		neg = '0;
		t = 128'h4000_0000_0000_0000;
		for (int k = 1; k <= 24; k++) begin
			t = ((t * y) >> 62) / k;
			if (k % 2) neg += t[63:0];
			else pos += t[63:0];
		end
		return (pos > neg) ? pos - neg : 64'd0;
	endfunction

	function automatic logic [56:0] density_of(logic signed [19:0] alt_in);
		logic [127:0] den, rho, hm, d, q, r, y, e, e1, prod;
		int unsigned  alt, idx;
		if (alt_in < 0) alt = 0;
		else alt = alt_in;
		if (alt > 300000) return '0;
		idx = 0;
		for (int i = 0; i < NSEG; i++)
			if (base_km_tab[i] <= alt / 1000) idx = i;
		den = 1;
		for (int i = 0; i < pow10_tab[idx]; i++) den = den * 10;
		rho = (128'(mant_tab[idx]) << 62) / den;
		d = alt - base_km_tab[idx] * 1000;
		hm = htens_tab[idx] * 10;
		q = d / hm;
		r = d % hm;
		y = (r << 62) / hm;
		e = exp_neg(y[63:0]);
		e1 = exp_neg(64'h4000_0000_0000_0000);
		for (int i = 0; i < q; i++) e = ((e * e1) >> 62) & 128'hFFFF_FFFF_FFFF_FFFF;
		prod = rho * e;
		prod = (prod + (128'd1 << 67)) >> 68;
		return prod[56:0];
	endfunction

	// sender: hold the payload until its transfer
	always @(negedge clk) begin
		if (!req_valid || req_took) begin
			if (pending_alt.size() > 0 && !send_pause && $urandom_range(99) >= send_idle) begin
				req_valid <= 1'b1;
				altitude_m <= pending_alt.pop_front();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted here
	always @(negedge clk) begin
		if (hold_trig != hold_seen) begin
			hold_seen <= hold_trig;
			hold_left <= HOLD_LEN;
			rsp_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		logic [56:0] want;
		req_took <= req_valid && req_ready;
		if (req_valid && req_ready) begin
			density_due.push_back(density_of(altitude_m));
			sent++;
		end
		if (rsp_valid && rsp_ready) begin
			received++;
			if (density_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transfer: density %h", density);
			end else begin
				want = density_due.pop_front();
				if (density !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("density mismatch: expected %h got %h", want, density);
				end
			end
		end
	end

	task automatic drain();
		while (pending_alt.size() > 0 || req_valid || density_due.size() > 0)
			@(posedge clk);
	endtask

	task automatic queue_random(int count);
		int unsigned pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 75) pending_alt.push_back(20'($urandom_range(300000)));
			else if (pick < 85) pending_alt.push_back(20'(300000 - $urandom_range(3)
				+ $urandom_range(3)));
			else pending_alt.push_back(20'($urandom));
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (base_km_tab[i]) pending_alt.push_back(20'(base_km_tab[i] * 1000));
		pending_alt.push_back(-20'sd524288);
		pending_alt.push_back(-20'sd1);
		pending_alt.push_back(20'sd1);
		pending_alt.push_back(20'sd299999);
		pending_alt.push_back(20'sd300001);
		pending_alt.push_back(20'sd524287);
		pending_alt.push_back(20'sd10419);
		drain();

		// receiver stalls often, then stop it outright so the pipe backs up
		send_idle = 15;
		recv_idle = 85;
		queue_random(530);
		while (pending_alt.size() > 400) @(posedge clk);
		hold_trig = 1;
		drain();

		// sender pauses until all results are back
		send_idle = 85;
		recv_idle = 15;
		queue_random(530);
		while (pending_alt.size() > 265) @(posedge clk);
		send_pause = 1'b1;
		while (req_valid || density_due.size() > 0) @(posedge clk);
		send_pause = 1'b0;
		drain();

		send_idle = 0;
		recv_idle = 0;
		queue_random(530);
		drain();
		repeat (FLUSH_CYCLES) @(posedge clk);

		$display("covered %0d altitude queries with %0d density results, including negative,",
			sent, received);
		$display("over-top and segment-edge altitudes under three stall mixes and a long hold-off");
		if (mismatches == 0 && density_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("mismatches %0d, results outstanding %0d", mismatches, density_due.size());
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#(8 * 300000);
		$display("timeout");
		$display("tb: failure");
		$finish;
	end

endmodule

`default_nettype wire
